>>> rtl/sv39_page_table_walker_defines.svh
// assertion helpers shared by the walker rtl
`ifndef SV39_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SV39PTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sv39ptw same-cycle check failed");

// next-cycle implication, checked outside reset
`define SV39PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sv39ptw next-cycle check failed");

`endif

>>> rtl/sv39ptw_pkg.sv
`timescale 1ns / 1ps

package sv39ptw_pkg;

  localparam int XLEN       = 64;
  localparam int PPN_W      = 44;
  localparam int VA_W       = 39;
  localparam int PA_W       = 56;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int VPN_W      = 9;
  localparam int PTE_SIZE_W = 3;

  // translation modes
  localparam logic [MODE_W-1:0] MODE_BARE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SV39 = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT = 2'd1;

  // input operations and result kinds
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_PTE     = 1'b1;
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef logic [1:0] level_t;

  localparam level_t LEVEL_TOP  = 2'd2;
  localparam level_t LEVEL_MID  = 2'd1;
  localparam level_t LEVEL_LEAF = 2'd0;
  localparam level_t LEVEL_NONE = 2'd3;

  // walk context kept between items
  typedef struct packed {
    logic              active;
    level_t            level;
    logic [PPN_W-1:0]  base_page;
    logic [VA_W-1:0]   vaddr;
    logic              store_access;
  } walk_state_t;

  // one incoming item
  typedef struct packed {
    logic            operation;
    logic [XLEN-1:0] virt_addr;
    logic            store_access;
    logic [XLEN-1:0] pte_word;
  } walk_item_t;

  // one result item
  typedef struct packed {
    logic            kind;
    logic [PA_W-1:0] entry_addr;
    logic [XLEN-1:0] phys_addr;
    logic            fault;
  } walk_result_t;

  // address of the entry indexed by the vpn slice of this level
  function automatic logic [PA_W-1:0] entry_addr_f(input logic [PPN_W-1:0] base,
                                                   input logic [VA_W-1:0] va,
                                                   input level_t lvl);
    logic [VPN_W-1:0] idx;
    unique case (lvl)
      LEVEL_LEAF: idx = va[20:12];
      LEVEL_MID:  idx = va[29:21];
      LEVEL_TOP:  idx = va[38:30];
      default:    idx = '0;
    endcase
    return {base, idx, {PTE_SIZE_W{1'b0}}};
  endfunction

endpackage

>>> rtl/sv39ptw_step.sv
`timescale 1ns / 1ps

module sv39ptw_step
  import sv39ptw_pkg::*;
(
  input  walk_item_t         item,
  input  walk_state_t        state,
  input  logic [MODE_W-1:0]  mode,
  input  logic [PPN_W-1:0]   root_page,
  output logic               has_result,
  output walk_result_t       result,
  output walk_state_t        state_nxt
);

  logic             pte_v;
  logic             pte_r;
  logic             pte_w;
  logic             pte_x;
  logic [PPN_W-1:0] pte_ppn;
  logic [PPN_W-1:0] low_mask;
  logic [VA_W-1:0]  off_mask;
  level_t           lvl_down;

  // entry fields
  assign pte_v   = item.pte_word[0];
  assign pte_r   = item.pte_word[1];
  assign pte_w   = item.pte_word[2];
  assign pte_x   = item.pte_word[3];
  assign pte_ppn = item.pte_word[53:10];
  assign lvl_down = state.level - 2'd1;

  // superpage masks for the current level
  always_comb begin
    unique case (state.level)
      LEVEL_LEAF: begin
        low_mask = 44'h0;
        off_mask = 39'hFFF;
      end
      LEVEL_MID: begin
        low_mask = 44'h1FF;
        off_mask = 39'h1F_FFFF;
      end
      LEVEL_TOP: begin
        low_mask = 44'h3_FFFF;
        off_mask = 39'h3FFF_FFFF;
      end
      default: begin
        low_mask = 44'h7FF_FFFF;
        off_mask = {VA_W{1'b1}};
      end
    endcase
  end

  // request start, entry check, leaf finish or descent
  always_comb begin
    state_nxt  = state;
    has_result = 1'b0;
    result     = '0;
    if (item.operation == OP_REQUEST) begin
      state_nxt.active = 1'b0;
      has_result       = 1'b1;
      result.kind      = KIND_DONE;
      priority if (mode == MODE_BARE) begin
        result.phys_addr = item.virt_addr;
      end else if (mode != MODE_SV39) begin
        result.fault = 1'b1;
      end else begin
        state_nxt.active       = 1'b1;
        state_nxt.level        = LEVEL_TOP;
        state_nxt.base_page    = root_page;
        state_nxt.vaddr        = item.virt_addr[VA_W-1:0];
        state_nxt.store_access = item.store_access;
        result.kind            = KIND_READ;
        result.entry_addr = entry_addr_f(root_page, item.virt_addr[VA_W-1:0], LEVEL_TOP);
      end
    end else if (state.active) begin
      has_result  = 1'b1;
      result.kind = KIND_DONE;
      priority if (!pte_v || (!pte_r && pte_w)) begin
        state_nxt.active = 1'b0;
        result.fault     = 1'b1;
      end else if (pte_r || pte_x) begin
        state_nxt.active = 1'b0;
        if ((state.store_access && !pte_w) || ((pte_ppn & low_mask) != '0)) begin
          result.fault = 1'b1;
        end else begin
          result.phys_addr = {8'h0, pte_ppn & ~low_mask, 12'h0}
                           | {25'h0, state.vaddr & off_mask};
        end
      end else if (state.level == LEVEL_LEAF) begin
        state_nxt.active = 1'b0;
        result.fault     = 1'b1;
      end else begin
        state_nxt.base_page = pte_ppn;
        state_nxt.level     = lvl_down;
        result.kind         = KIND_READ;
        result.entry_addr   = entry_addr_f(pte_ppn, state.vaddr, lvl_down);
      end
    end
  end

endmodule

>>> rtl/sv39_page_table_walker.sv
`timescale 1ns / 1ps
// Sv39 page table walker
// input channel: in_valid/in_stall with in_operation, in_virt_addr, in_store_access,
//   in_pte_word. operation 0 starts a translation, 1 hands back a fetched entry.
// result channel: out_valid/out_stall with out_kind, out_entry_addr, out_phys_addr,
//   out_fault. kind 0 asks memory for the entry at out_entry_addr; the entry comes
//   back as a later input item. kind 1 ends the translation.
// config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 mode, 1 root ppn.
// the result of an item is registered and appears in the cycle after it is accepted.
// throughput: one item per cycle while in_stall is low; each item is checked
//   combinationally between the walk state register and the output register. a full
//   walk costs three round trips through memory, which set the pace of one translation.
// an entry arriving with no walk in progress is taken and gives no result.
// a new request drops any walk in progress.
// stall: in_stall rises only while a result is held and out_stall is high; the
//   held result and its fields stay put until taken.
// reset (rst_n low, synchronous): mode bare, root 0, no walk, output empty.

module sv39_page_table_walker
  import sv39ptw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [XLEN-1:0]      in_virt_addr,
  input  logic                 in_store_access,
  input  logic [XLEN-1:0]      in_pte_word,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [PA_W-1:0]      out_entry_addr,
  output logic [XLEN-1:0]      out_phys_addr,
  output logic                 out_fault,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [XLEN-1:0]      cfg_wdata
);

`include "sv39_page_table_walker_defines.svh"

  logic [MODE_W-1:0] mode_r;
  logic [PPN_W-1:0]  root_r;
  walk_state_t       walk_r;
  walk_state_t       walk_nxt;
  walk_item_t        item;
  walk_result_t      res_nxt;
  walk_result_t      res_r;
  logic              has_result;
  logic              out_valid_r;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign item.operation    = in_operation;
  assign item.virt_addr    = in_virt_addr;
  assign item.store_access = in_store_access;
  assign item.pte_word     = in_pte_word;

  sv39ptw_step u_step (
    .item       (item),
    .state      (walk_r),
    .mode       (mode_r),
    .root_page  (root_r),
    .has_result (has_result),
    .result     (res_nxt),
    .state_nxt  (walk_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BARE;
      root_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_wdata[MODE_W-1:0];
      end else if (cfg_index == REG_ROOT) begin
        root_r <= cfg_wdata[PPN_W-1:0];
      end
    end
  end

  // walk state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= '0;
    end else if (in_accept) begin
      walk_r <= walk_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && has_result) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_entry_addr = res_r.entry_addr;
  assign out_phys_addr  = res_r.phys_addr;
  assign out_fault      = res_r.fault;

  // a read request never carries a finished address or a fault
  `SV39PTW_ASSERT_NOW(a_read_clean, clk, rst_n, out_valid_r && out_kind == KIND_READ, out_fault == 1'b0 && out_phys_addr == '0)
  // a finished translation never carries an entry address
  `SV39PTW_ASSERT_NOW(a_done_no_addr, clk, rst_n, out_valid_r && out_kind == KIND_DONE, out_entry_addr == '0)
  // an active walk is always on one of the three levels
  `SV39PTW_ASSERT_NOW(a_level_range, clk, rst_n, walk_r.active, walk_r.level != LEVEL_NONE)
  // an entry with no walk in progress gives no result, so the output is empty after it
  `SV39PTW_ASSERT_NEXT(a_stray_entry, clk, rst_n, in_accept && in_operation == OP_PTE && !walk_r.active, out_valid_r == 1'b0)
  // an sv39 request opens a walk at the top level
  `SV39PTW_ASSERT_NEXT(a_walk_start, clk, rst_n, in_accept && in_operation == OP_REQUEST && mode_r == MODE_SV39, walk_r.active && walk_r.level == LEVEL_TOP && out_kind == KIND_READ)

endmodule
